### src/sle_pkg.sv
package sle_pkg;

    localparam int CapacityDefault = 16;
    localparam int DataWidth = 32;
    localparam int FieldWidth = 5;
    localparam int QueueDepth = 2;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_LOCATE = 2'd2,
        OP_DELMIN = 2'd3
    } op_t;

    // Command handed from the front end to the back end.
    typedef struct packed {
        op_t                      op;
        logic [FieldWidth-1:0]    position;
        logic [DataWidth-1:0]     value;
        logic [FieldWidth-1:0]    limit;
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SHIFT_UP,
        ST_SHIFT_DOWN,
        ST_SCAN,
        ST_MIN_MOVE,
        ST_RESULT
    } state_t;

endpackage

### src/sle_front.sv
module sle_front #(
    parameter int CAPACITY = sle_pkg::CapacityDefault
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [sle_pkg::FieldWidth-1:0]    cfg_data,
    input  logic                              valid_in,
    output logic                              ready_in,
    input  logic [1:0]                        operation,
    input  logic [sle_pkg::FieldWidth-1:0]    position,
    input  logic [sle_pkg::DataWidth-1:0]     value,
    output logic                              cmd_valid,
    input  logic                              cmd_ready,
    output sle_pkg::cmd_t                     cmd
);

    logic [sle_pkg::FieldWidth-1:0] limit_reg;
    logic [sle_pkg::FieldWidth-1:0] limit_eff;
    sle_pkg::cmd_t                  q_reg [sle_pkg::QueueDepth];
    logic                           wp_reg, rp_reg;
    logic [1:0]                     cnt_reg;
    logic                           push, pop;

    // Capacity register, saturated to the store depth when used.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            limit_reg <= sle_pkg::FieldWidth'(16);
        else if (cfg_we)
            limit_reg <= cfg_data;
    end

    always_comb
    begin
        if (32'(limit_reg) > CAPACITY)
            limit_eff = sle_pkg::FieldWidth'(CAPACITY);
        else
            limit_eff = limit_reg;
    end

    assign ready_in  = (cnt_reg != 2'd2);
    assign push      = valid_in && ready_in;
    assign cmd_valid = (cnt_reg != 2'd0);
    assign pop       = cmd_valid && cmd_ready;
    assign cmd       = q_reg[rp_reg];

    // Two-entry command queue between front and back.
    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[wp_reg] <= '{op: sle_pkg::op_t'(operation), position: position,
                               value: value, limit: limit_eff};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
                wp_reg <= ~wp_reg;
            if (pop)
                rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n) cnt_reg <= 2'd2)
        else $error("queue count overflow");
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg == 2'd2 |-> !push) else $error("push into full queue");
    a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> cnt_reg != 2'd0) else $error("pop from empty queue");

endmodule

### src/sle_back.sv
module sle_back #(
    parameter int CAPACITY = sle_pkg::CapacityDefault
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cmd_valid,
    output logic                              cmd_ready,
    input  sle_pkg::cmd_t                     cmd,
    output logic                              valid_out,
    input  logic                              ready_out,
    output logic                              ok,
    output logic [sle_pkg::DataWidth-1:0]     value_out,
    output logic [sle_pkg::FieldWidth-1:0]    position_out,
    output logic [sle_pkg::FieldWidth-1:0]    list_length_out,
    output logic                              last
);

    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int LW = $clog2(CAPACITY + 1);
    localparam int HW = (LW > sle_pkg::FieldWidth) ? LW : sle_pkg::FieldWidth;

    logic [sle_pkg::DataWidth-1:0] mem [CAPACITY];
    logic [sle_pkg::DataWidth-1:0] rd_reg;

    sle_pkg::state_t state_reg, state_next;
    sle_pkg::cmd_t   c_reg, c_next;
    logic [LW-1:0]   len_reg, len_next;
    logic [LW-1:0]   j_reg, j_next;
    logic [LW-1:0]   at_reg, at_next;
    logic [sle_pkg::DataWidth-1:0] min_reg, min_next;
    logic [4:0]      hits_reg, hits_next;
    logic            found_reg, found_next;
    logic            pend_reg, pend_next;
    logic [LW-1:0]   pendpos_reg, pendpos_next;

    logic            ov_reg, ov_next;
    logic            ok_reg, ok_next;
    logic [sle_pkg::DataWidth-1:0] vo_reg, vo_next;
    logic [sle_pkg::FieldWidth-1:0] po_reg, po_next;
    logic [sle_pkg::FieldWidth-1:0] lo_reg, lo_next;
    logic            last_reg, last_next;

    logic            we;
    logic [IW-1:0]   wa, ra;
    logic [sle_pkg::DataWidth-1:0] wd;
    logic            ra_en;
    logic [HW-1:0]   posx, lenx;

    assign valid_out       = ov_reg;
    assign ok              = ok_reg;
    assign value_out       = vo_reg;
    assign position_out    = po_reg;
    assign list_length_out = lo_reg;
    assign last            = last_reg;

    // Single-port-write, single-read store with registered read data.
    always_ff @(posedge clk)
    begin
        if (we)
            mem[wa] <= wd;
        if (ra_en)
            rd_reg <= mem[ra];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sle_pkg::ST_IDLE;
            len_reg   <= '0;
            ov_reg    <= 1'b0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            len_reg   <= len_next;
            ov_reg    <= ov_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        c_reg       <= c_next;
        j_reg       <= j_next;
        at_reg      <= at_next;
        min_reg     <= min_next;
        hits_reg    <= hits_next;
        found_reg   <= found_next;
        pendpos_reg <= pendpos_next;
        ok_reg      <= ok_next;
        vo_reg      <= vo_next;
        po_reg      <= po_next;
        lo_reg      <= lo_next;
        last_reg    <= last_next;
    end

    assign posx = HW'(cmd.position);
    assign lenx = HW'(len_reg);

    // Sequencer: at most one store write and one store read per cycle; results go through one output register.
    always_comb
    begin
        state_next   = state_reg;
        c_next       = c_reg;
        len_next     = len_reg;
        j_next       = j_reg;
        at_next      = at_reg;
        min_next     = min_reg;
        hits_next    = hits_reg;
        found_next   = found_reg;
        pend_next    = pend_reg;
        pendpos_next = pendpos_reg;
        ov_next      = ov_reg && !ready_out;
        ok_next      = ok_reg;
        vo_next      = vo_reg;
        po_next      = po_reg;
        lo_next      = lo_reg;
        last_next    = last_reg;
        cmd_ready    = 1'b0;
        we           = 1'b0;
        wa           = '0;
        wd           = '0;
        ra_en        = 1'b0;
        ra           = '0;

        unique case (state_reg)
            sle_pkg::ST_IDLE:
            begin
                if (cmd_valid && (!ov_reg || ready_out))
                begin
                    cmd_ready = 1'b1;
                    c_next    = cmd;
                    ov_next   = 1'b0;
                    unique case (cmd.op)
                        sle_pkg::OP_INSERT:
                        begin
                            if (posx < HW'(1) || posx > lenx + HW'(1) ||
                                lenx >= HW'(cmd.limit))
                            begin
                                ov_next = 1'b1; ok_next = 1'b0; vo_next = '0;
                                po_next = '0; lo_next = 5'(len_reg); last_next = 1'b1;
                            end
                            else
                            begin
                                // Walk downward from the end, moving entries up.
                                j_next = len_reg;
                                if (lenx >= posx)
                                begin
                                    ra_en = 1'b1;
                                    ra    = IW'(len_reg - LW'(1));
                                end
                                state_next = sle_pkg::ST_SHIFT_UP;
                            end
                        end
                        sle_pkg::OP_DELETE:
                        begin
                            if (posx < HW'(1) || posx > lenx)
                            begin
                                ov_next = 1'b1; ok_next = 1'b0; vo_next = '0;
                                po_next = '0; lo_next = 5'(len_reg); last_next = 1'b1;
                            end
                            else
                            begin
                                ra_en  = 1'b1;
                                ra     = IW'(cmd.position - 5'd1);
                                j_next = LW'(cmd.position - 5'd1);
                                found_next = 1'b0;
                                state_next = sle_pkg::ST_SHIFT_DOWN;
                            end
                        end
                        sle_pkg::OP_LOCATE:
                        begin
                            j_next     = '0;
                            hits_next  = '0;
                            found_next = 1'b0;
                            pend_next  = 1'b0;
                            if (len_reg != '0)
                            begin
                                ra_en = 1'b1;
                                ra    = '0;
                            end
                            state_next = sle_pkg::ST_SCAN;
                        end
                        default:
                        begin
                            if (len_reg == '0)
                            begin
                                ov_next = 1'b1; ok_next = 1'b0; vo_next = '0;
                                po_next = '0; lo_next = 5'(len_reg); last_next = 1'b1;
                            end
                            else
                            begin
                                ra_en  = 1'b1;
                                ra     = '0;
                                j_next = '0;
                                at_next = '0;
                                state_next = sle_pkg::ST_SCAN;
                            end
                        end
                    endcase
                end
            end

            // Insert: rd_reg holds entry j-1; write it to j, then read j-2.
            sle_pkg::ST_SHIFT_UP:
            begin
                if (HW'(j_reg) >= HW'(c_reg.position))
                begin
                    we = 1'b1;
                    wa = IW'(j_reg);
                    wd = rd_reg;
                    j_next = j_reg - LW'(1);
                    if (HW'(j_reg) - HW'(1) >= HW'(c_reg.position))
                    begin
                        ra_en = 1'b1;
                        ra    = IW'(j_reg - LW'(2));
                    end
                end
                else
                begin
                    we = 1'b1;
                    wa = IW'(c_reg.position - 5'd1);
                    wd = c_reg.value;
                    len_next = len_reg + LW'(1);
                    state_next = sle_pkg::ST_RESULT;
                    ok_next = 1'b1; vo_next = '0; po_next = '0;
                    lo_next = 5'(len_reg + LW'(1)); last_next = 1'b1;
                end
            end

            // Delete: the first step latches the removed value, then entry j+1 moves to j.
            sle_pkg::ST_SHIFT_DOWN:
            begin
                if (!found_reg)
                begin
                    found_next = 1'b1;
                    min_next   = rd_reg;
                    if (j_reg + LW'(1) < len_reg)
                    begin
                        ra_en = 1'b1;
                        ra    = IW'(j_reg + LW'(1));
                    end
                    else
                    begin
                        len_next = len_reg - LW'(1);
                        state_next = sle_pkg::ST_RESULT;
                        ok_next = 1'b1; vo_next = rd_reg; po_next = '0;
                        lo_next = 5'(len_reg - LW'(1)); last_next = 1'b1;
                    end
                end
                else
                begin
                    we = 1'b1;
                    wa = IW'(j_reg);
                    wd = rd_reg;
                    j_next = j_reg + LW'(1);
                    if (j_reg + LW'(2) < len_reg)
                    begin
                        ra_en = 1'b1;
                        ra    = IW'(j_reg + LW'(2));
                    end
                    else
                    begin
                        len_next = len_reg - LW'(1);
                        state_next = sle_pkg::ST_RESULT;
                        ok_next = 1'b1; vo_next = min_reg; po_next = '0;
                        lo_next = 5'(len_reg - LW'(1)); last_next = 1'b1;
                    end
                end
            end

            // Scan: rd_reg holds entry j. Locate hands out hits; delete-min tracks minimum.
            sle_pkg::ST_SCAN:
            begin
                if (c_reg.op == sle_pkg::OP_LOCATE)
                begin
                    if (!pend_reg || !ov_reg || ready_out)
                    begin
                        logic hit;
                        logic done;
                        hit  = (j_reg < len_reg) && (rd_reg == c_reg.value)
                               && (hits_reg != 5'd16);
                        done = (j_reg >= len_reg) || (hits_reg == 5'd16);
                        // Flush the held hit once we know whether it is the last one.
                        if (pend_reg && (hit || done))
                        begin
                            ov_next = 1'b1; ok_next = 1'b1; vo_next = '0;
                            po_next = 5'(pendpos_reg); lo_next = 5'(len_reg);
                            last_next = done;
                            pend_next = 1'b0;
                        end
                        if (done)
                        begin
                            if (!pend_reg)
                            begin
                                ov_next = 1'b1; ok_next = 1'b0; vo_next = '0;
                                po_next = '0; lo_next = 5'(len_reg); last_next = 1'b1;
                            end
                            state_next = sle_pkg::ST_IDLE;
                        end
                        else
                        begin
                            if (hit)
                            begin
                                pend_next    = 1'b1;
                                pendpos_next = j_reg + LW'(1);
                                hits_next    = hits_reg + 5'd1;
                            end
                            j_next = j_reg + LW'(1);
                            if (j_reg + LW'(1) < len_reg)
                            begin
                                ra_en = 1'b1;
                                ra    = IW'(j_reg + LW'(1));
                            end
                        end
                    end
                end
                else
                begin
                    if (j_reg == '0 || $signed(rd_reg) < $signed(min_reg))
                    begin
                        min_next = rd_reg;
                        at_next  = j_reg;
                    end
                    j_next = j_reg + LW'(1);
                    if (j_reg + LW'(1) < len_reg)
                    begin
                        ra_en = 1'b1;
                        ra    = IW'(j_reg + LW'(1));
                    end
                    else
                    begin
                        ra_en = 1'b1;
                        ra    = IW'(len_reg - LW'(1));
                        state_next = sle_pkg::ST_MIN_MOVE;
                    end
                end
            end

            // Delete-min: rd_reg holds the last entry; move it into the freed slot.
            sle_pkg::ST_MIN_MOVE:
            begin
                we = 1'b1;
                wa = IW'(at_reg);
                wd = rd_reg;
                len_next = len_reg - LW'(1);
                state_next = sle_pkg::ST_RESULT;
                ok_next = 1'b1; vo_next = min_reg; po_next = 5'(at_reg + LW'(1));
                lo_next = 5'(len_reg - LW'(1)); last_next = 1'b1;
            end

            sle_pkg::ST_RESULT:
            begin
                if (!ov_reg || ready_out)
                begin
                    ov_next = 1'b1;
                    state_next = sle_pkg::ST_IDLE;
                end
                else
                begin
                    ok_next = ok_reg; vo_next = vo_reg; po_next = po_reg;
                    lo_next = lo_reg; last_next = last_reg;
                end
            end

            default:
                state_next = sle_pkg::ST_IDLE;
        endcase

        // A result still waiting holds its fields.
        if (ov_reg && !ready_out)
        begin
            ok_next = ok_reg; vo_next = vo_reg; po_next = po_reg;
            lo_next = lo_reg; last_next = last_reg;
        end
    end

    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(len_reg) <= CAPACITY) else $error("length beyond capacity");
    a_take_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_ready |-> state_reg == sle_pkg::ST_IDLE) else $error("command taken while busy");
    a_len_step: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg != $past(len_reg) |-> $past(state_reg) != sle_pkg::ST_IDLE)
        else $error("length changed outside an operation");

endmodule

### src/sequential_list_engine_core.sv
// Sequential list engine: an ordered list of signed 32-bit values.
// Input channel: valid_in/ready_in with operation, position and value;
// a transfer happens when both are high. Output channel: valid_out/ready_out
// with ok, value_out, position_out, list_length_out and last.
// cfg_we/cfg_data write capacity_limit at any edge with cfg_we high.
// A front part takes items into a two-entry command queue; a back part runs
// them against a CAPACITY-entry store (16 by default) with one write and one registered read a cycle.
// The back part walks the store one entry per cycle, and a locate waits while
// a held hit cannot be handed out; a refused item goes straight to the output
// register. The back part takes its next item only once back in idle.
// Locate gives one result per hit (up to 16), last set on the final one, or one failing result if none hit.
// A stalled receiver holds the result register; the back part then waits,
// while the queue still takes up to two more items.
// Reset empties the list, clears the queue and sets capacity_limit to 16.
module sequential_list_engine_core #(
    parameter int CAPACITY = sle_pkg::CapacityDefault
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [sle_pkg::FieldWidth-1:0]    cfg_data,
    input  logic                              valid_in,
    output logic                              ready_in,
    input  logic [1:0]                        operation,
    input  logic [sle_pkg::FieldWidth-1:0]    position,
    input  logic [sle_pkg::DataWidth-1:0]     value,
    output logic                              valid_out,
    input  logic                              ready_out,
    output logic                              ok,
    output logic [sle_pkg::DataWidth-1:0]     value_out,
    output logic [sle_pkg::FieldWidth-1:0]    position_out,
    output logic [sle_pkg::FieldWidth-1:0]    list_length_out,
    output logic                              last
);

    logic          cmd_valid, cmd_ready;
    sle_pkg::cmd_t cmd;

    sle_front #(.CAPACITY(CAPACITY)) u_front (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
        .valid_in(valid_in), .ready_in(ready_in), .operation(operation),
        .position(position), .value(value), .cmd_valid(cmd_valid),
        .cmd_ready(cmd_ready), .cmd(cmd)
    );

    sle_back #(.CAPACITY(CAPACITY)) u_back (
        .clk(clk), .rst_n(rst_n), .cmd_valid(cmd_valid), .cmd_ready(cmd_ready),
        .cmd(cmd), .valid_out(valid_out), .ready_out(ready_out), .ok(ok),
        .value_out(value_out), .position_out(position_out),
        .list_length_out(list_length_out), .last(last)
    );

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

    localparam int Capacity = 16;
    localparam int WatchdogLimit = 20000;
    localparam int DrainCycles = 60;

    // One pending list operation.
    typedef struct {
        sle_pkg::op_t                   op;
        logic [sle_pkg::FieldWidth-1:0] pos;
        logic [sle_pkg::DataWidth-1:0]  val;
    } list_op_t;

    // One expected engine response.
    typedef struct {
        logic                           ok;
        logic [sle_pkg::DataWidth-1:0]  val;
        logic [sle_pkg::FieldWidth-1:0] pos;
        logic [sle_pkg::FieldWidth-1:0] len;
        logic                           last;
    } list_resp_t;

    logic                           clk;
    logic                           rst_n;
    logic                           cfg_we;
    logic [sle_pkg::FieldWidth-1:0] cfg_data;
    logic                           valid_in;
    logic                           ready_in;
    logic [1:0]                     operation;
    logic [sle_pkg::FieldWidth-1:0] position;
    logic [sle_pkg::DataWidth-1:0]  value;
    logic                           valid_out;
    logic                           ready_out;
    logic                           ok;
    logic [sle_pkg::DataWidth-1:0]  value_out;
    logic [sle_pkg::FieldWidth-1:0] position_out;
    logic [sle_pkg::FieldWidth-1:0] list_length_out;
    logic                           last;

    list_op_t   op_queue[$];
    list_resp_t resp_queue[$];

    // Shadow copy of the list used for prediction.
    logic [sle_pkg::DataWidth-1:0]  shadow_list[Capacity];
    int                             shadow_len;
    int                             shadow_limit;
    // Values currently in the list as the generator sees them.
    logic [sle_pkg::DataWidth-1:0]  gen_list[$];
    int                             gen_limit;

    int  mismatch_count;
    int  idle_cycles = 0;
    int  send_idle_pct;
    int  recv_idle_pct;
    bit  stim_done;

    sequential_list_engine_core #(
        .CAPACITY(Capacity)
    ) DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_data       (cfg_data),
        .valid_in       (valid_in),
        .ready_in       (ready_in),
        .operation      (operation),
        .position       (position),
        .value          (value),
        .valid_out      (valid_out),
        .ready_out      (ready_out),
        .ok             (ok),
        .value_out      (value_out),
        .position_out   (position_out),
        .list_length_out(list_length_out),
        .last           (last)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    task automatic report_mismatch(input string what,
                                   input logic [sle_pkg::DataWidth-1:0] got,
                                   input logic [sle_pkg::DataWidth-1:0] want);
        $display("MISMATCH at %0t: %s got %0h expected %0h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    function automatic list_resp_t make_resp(logic okv, logic [sle_pkg::DataWidth-1:0] v,
                                             int p, logic lst);
        list_resp_t r;
        r.ok   = okv;
        r.val  = v;
        r.pos  = p[sle_pkg::FieldWidth-1:0];
        r.len  = shadow_len[sle_pkg::FieldWidth-1:0];
        r.last = lst;
        return r;
    endfunction

    // Apply one accepted operation to the shadow list and queue its responses.
    task automatic predict_list_op(input list_op_t t);
        int p;
        int hits;
        int at;
        logic [sle_pkg::DataWidth-1:0] removed;
        int hit_pos[$];
        p = int'(t.pos);
        case (t.op)
            sle_pkg::OP_INSERT:
            begin
                if (p < 1 || p > shadow_len + 1 || shadow_len >= shadow_limit)
                begin
                    resp_queue.push_back(make_resp(1'b0, '0, 0, 1'b1));
                end
                else
                begin
                    for (int j = shadow_len; j >= p; j--)
                        shadow_list[j] = shadow_list[j-1];
                    shadow_list[p-1] = t.val;
                    shadow_len++;
                    resp_queue.push_back(make_resp(1'b1, '0, 0, 1'b1));
                end
            end
            sle_pkg::OP_DELETE:
            begin
                if (p < 1 || p > shadow_len)
                begin
                    resp_queue.push_back(make_resp(1'b0, '0, 0, 1'b1));
                end
                else
                begin
                    removed = shadow_list[p-1];
                    for (int j = p; j < shadow_len; j++)
                        shadow_list[j-1] = shadow_list[j];
                    shadow_len--;
                    resp_queue.push_back(make_resp(1'b1, removed, 0, 1'b1));
                end
            end
            sle_pkg::OP_LOCATE:
            begin
                for (int j = 0; j < shadow_len; j++)
                    if (shadow_list[j] == t.val && hit_pos.size() < 16)
                        hit_pos.push_back(j + 1);
                hits = hit_pos.size();
                if (hits == 0)
                    resp_queue.push_back(make_resp(1'b0, '0, 0, 1'b1));
                for (int k = 0; k < hits; k++)
                    resp_queue.push_back(make_resp(1'b1, '0, hit_pos[k], k == hits - 1));
            end
            default:
            begin
                if (shadow_len == 0)
                begin
                    resp_queue.push_back(make_resp(1'b0, '0, 0, 1'b1));
                end
                else
                begin
                    at = 0;
                    for (int j = 1; j < shadow_len; j++)
                        if ($signed(shadow_list[j]) < $signed(shadow_list[at]))
                            at = j;
                    removed = shadow_list[at];
                    shadow_list[at] = shadow_list[shadow_len-1];
                    shadow_len--;
                    resp_queue.push_back(make_resp(1'b1, removed, at + 1, 1'b1));
                end
            end
        endcase
    endtask

    // Queue an operation and track the list contents the generator expects.
    task automatic queue_list_op(input sle_pkg::op_t o, input int p,
                                 input logic [sle_pkg::DataWidth-1:0] v);
        list_op_t t;
        int at;
        t.op  = o;
        t.pos = p[sle_pkg::FieldWidth-1:0];
        t.val = v;
        op_queue.push_back(t);
        case (o)
            sle_pkg::OP_INSERT:
                if (p >= 1 && p <= gen_list.size() + 1 && gen_list.size() < gen_limit)
                    gen_list.insert(p - 1, v);
            sle_pkg::OP_DELETE:
                if (p >= 1 && p <= gen_list.size())
                    gen_list.delete(p - 1);
            sle_pkg::OP_DELMIN:
                if (gen_list.size() > 0)
                begin
                    at = 0;
                    for (int j = 1; j < gen_list.size(); j++)
                        if ($signed(gen_list[j]) < $signed(gen_list[at]))
                            at = j;
                    gen_list[at] = gen_list[gen_list.size()-1];
                    gen_list.pop_back();
                end
            default:
            begin
            end
        endcase
    endtask

    function automatic logic [sle_pkg::DataWidth-1:0] pick_value();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return $urandom_range(0, 3);
            3: return 32'hffff_fffe + $urandom_range(0, 1);
            default: return $urandom();
        endcase
    endfunction

    // Wait for every expected response, then let the engine settle.
    task automatic wait_idle();
        while (op_queue.size() != 0 || resp_queue.size() != 0)
            @(posedge clk);
        repeat (DrainCycles) @(posedge clk);
    endtask

    task automatic write_capacity(input int lim);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= lim[sle_pkg::FieldWidth-1:0];
        @(posedge clk);
        cfg_we   <= 1'b0;
        shadow_limit = (lim < Capacity) ? lim : Capacity;
        gen_limit    = shadow_limit;
    endtask

    task automatic random_phase(input int count);
        int  roll;
        logic [sle_pkg::DataWidth-1:0] v;
        for (int i = 0; i < count; i++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 40)
            begin
                v = (gen_list.size() > 0 && $urandom_range(0, 2) == 0)
                    ? gen_list[$urandom_range(0, gen_list.size() - 1)] : pick_value();
                queue_list_op(sle_pkg::OP_INSERT, ($urandom_range(0, 9) == 0)
                    ? $urandom_range(0, 31) : $urandom_range(1, gen_list.size() + 1), v);
            end
            else if (roll < 60)
            begin
                queue_list_op(sle_pkg::OP_DELETE, ($urandom_range(0, 9) == 0)
                    ? $urandom_range(0, 31) : $urandom_range(1, gen_list.size() + 1),
                    $urandom());
            end
            else if (roll < 82)
            begin
                v = (gen_list.size() > 0 && $urandom_range(0, 3) != 0)
                    ? gen_list[$urandom_range(0, gen_list.size() - 1)] : pick_value();
                queue_list_op(sle_pkg::OP_LOCATE, $urandom_range(0, 31), v);
            end
            else
            begin
                queue_list_op(sle_pkg::OP_DELMIN, $urandom_range(0, 31), $urandom());
            end
        end
    endtask

    // Driver: present the oldest pending operation.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_in  <= 1'b0;
            operation <= '0;
            position  <= '0;
            value     <= '0;
        end
        else
        begin
            if (valid_in && ready_in)
            begin
                predict_list_op(op_queue.pop_front());
            end
            // The head of the queue is the next item once the current one transferred.
            if (!valid_in || ready_in)
            begin
                if (op_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    valid_in  <= 1'b1;
                    operation <= op_queue[0].op;
                    position  <= op_queue[0].pos;
                    value     <= op_queue[0].val;
                end
                else
                begin
                    valid_in <= 1'b0;
                end
            end
        end
    end

    // Receiver back-pressure.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ready_out <= 1'b0;
        else
            ready_out <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Monitor: compare each response transfer with the oldest expectation.
    always @(posedge clk)
    begin
        list_resp_t want;
        if (rst_n && valid_out && ready_out)
        begin
            if (resp_queue.size() == 0)
            begin
                report_mismatch("unexpected response", value_out, '0);
            end
            else
            begin
                want = resp_queue.pop_front();
                if (ok !== want.ok)
                    report_mismatch("ok", sle_pkg::DataWidth'(ok),
                                    sle_pkg::DataWidth'(want.ok));
                if (value_out !== want.val)
                    report_mismatch("value_out", value_out, want.val);
                if (position_out !== want.pos)
                    report_mismatch("position_out", sle_pkg::DataWidth'(position_out),
                                    sle_pkg::DataWidth'(want.pos));
                if (list_length_out !== want.len)
                    report_mismatch("list_length_out", sle_pkg::DataWidth'(list_length_out),
                                    sle_pkg::DataWidth'(want.len));
                if (last !== want.last)
                    report_mismatch("last", sle_pkg::DataWidth'(last),
                                    sle_pkg::DataWidth'(want.last));
            end
        end
    end

    // Watchdog: cycles without any transfer while operations or responses are pending.
    always @(posedge clk)
    begin
        if ((valid_in && ready_in) || (valid_out && ready_out) || stim_done
            || (op_queue.size() == 0 && resp_queue.size() == 0))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WatchdogLimit)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Stimulus sequence.
    initial
    begin
        cfg_we         = 1'b0;
        cfg_data       = '0;
        mismatch_count = 0;
        stim_done      = 1'b0;
        shadow_len     = 0;
        shadow_limit   = Capacity;
        gen_limit      = Capacity;
        send_idle_pct  = 15;
        recv_idle_pct  = 57;
        foreach (shadow_list[i])
            shadow_list[i] = '0;
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: empty-list failures, bad positions, extremes, ties.
        queue_list_op(sle_pkg::OP_DELMIN, 0, 0);
        queue_list_op(sle_pkg::OP_DELETE, 1, 0);
        queue_list_op(sle_pkg::OP_LOCATE, 0, 32'h0);
        queue_list_op(sle_pkg::OP_INSERT, 0, 32'h5);
        queue_list_op(sle_pkg::OP_INSERT, 2, 32'h5);
        queue_list_op(sle_pkg::OP_INSERT, 1, 32'h7fff_ffff);
        queue_list_op(sle_pkg::OP_INSERT, 1, 32'h8000_0000);
        queue_list_op(sle_pkg::OP_INSERT, 3, 32'h8000_0000);
        queue_list_op(sle_pkg::OP_INSERT, 2, 32'h0);
        queue_list_op(sle_pkg::OP_LOCATE, 31, 32'h8000_0000);
        queue_list_op(sle_pkg::OP_DELMIN, 0, 0);
        queue_list_op(sle_pkg::OP_DELETE, 31, 0);
        queue_list_op(sle_pkg::OP_DELETE, 0, 0);
        queue_list_op(sle_pkg::OP_DELETE, 3, 0);
        queue_list_op(sle_pkg::OP_DELETE, 1, 0);
        // Empty the list, then fill with one value so locate hits all sixteen slots.
        while (gen_list.size() > 0)
            queue_list_op(sle_pkg::OP_DELETE, 1, 0);
        while (gen_list.size() < Capacity)
            queue_list_op(sle_pkg::OP_INSERT, gen_list.size() + 1, 32'hffff_ffff);
        queue_list_op(sle_pkg::OP_INSERT, 1, 32'h1);
        queue_list_op(sle_pkg::OP_LOCATE, 0, 32'hffff_ffff);
        queue_list_op(sle_pkg::OP_DELETE, 16, 0);
        wait_idle();

        random_phase(50);
        wait_idle();

        // Smallest limits: zero blocks all inserts, one allows a single entry; 31 saturates to the store depth.
        send_idle_pct = 57;
        recv_idle_pct = 15;
        write_capacity(0);
        random_phase(15);
        wait_idle();
        write_capacity(1);
        random_phase(20);
        wait_idle();
        write_capacity(31);
        random_phase(30);
        wait_idle();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_capacity(5);
        random_phase(25);
        wait_idle();
        write_capacity(16);
        random_phase(25);
        wait_idle();

        stim_done = 1'b1;
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
